// File: rtl/spxd_pkg.sv
// Shared types, constants and key helper for the sensor packet descrambler.
package spxd_pkg;

  localparam logic [31:0] KEY_ADD    = 32'hA2C71735;
  localparam logic [7:0]  KEY_FIXED  = 8'h47;
  localparam int unsigned DATA_FIRST = 5;
  localparam int unsigned DATA_COUNT = 13;
  localparam int unsigned DATA_IDX_W = 4;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [31:0] serial;
    logic [15:0] packet_count;
    logic [15:0] avg_time;
    logic [31:0] pulse_count;
    logic [7:0]  power_level;
    logic        serial_match;
  } spxd_result_t;

  // The key repeats every five data bytes: sum byte 3, byte 0, byte 1, the
  // fixed byte, then sum byte 2.
  function automatic byte_t key_byte(input logic [DATA_IDX_W-1:0] k,
                                     input logic [31:0] s);
    byte_t kb;
    case (k)
      4'd0, 4'd5, 4'd10: kb = s[31:24];
      4'd1, 4'd6, 4'd11: kb = s[7:0];
      4'd2, 4'd7, 4'd12: kb = s[15:8];
      4'd3, 4'd8:        kb = KEY_FIXED;
      4'd4, 4'd9:        kb = s[23:16];
      default:           kb = '0;
    endcase
    return kb;
  endfunction

endpackage

// File: rtl/spxd_frame.sv
// Byte position tracking, descrambling store and result unpacking.
module spxd_frame import spxd_pkg::*; #(
  parameter int PACKET_BYTES = 18
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  byte_t        pkt_byte,
  input  logic         packet_start,
  input  logic [31:0]  expected_serial,
  output logic         last,
  output spxd_result_t result
);

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(DATA_FIRST);
  localparam logic [POS_W-1:0] POS_END   = POS_W'(DATA_FIRST + DATA_COUNT);

  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_nxt;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_off;
  logic [DATA_IDX_W-1:0] data_idx;
  logic                  data_wr;
  logic [31:0]           key_sum;
  byte_t                 plain;
  byte_t                 store_r [DATA_COUNT];
  byte_t                 view    [DATA_COUNT];
  logic [31:0]           dec_serial;

  assign pos      = packet_start ? '0 : pos_r;
  assign last     = (pos == POS_LAST);
  assign pos_nxt  = last ? '0 : pos + POS_W'(1);
  assign pos_off  = pos - POS_FIRST;
  assign data_idx = pos_off[DATA_IDX_W-1:0];
  assign data_wr  = (pos >= POS_FIRST) && (pos < POS_END);
  assign key_sum  = expected_serial + KEY_ADD;
  assign plain    = pkt_byte ^ key_byte(data_idx, key_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && data_wr) begin
      store_r[data_idx] <= plain;
    end
  end

  // The last packet byte may itself be a data byte, so it is forwarded into
  // the unpacking view in the same cycle it is stored.
  always_comb begin
    for (int i = 0; i < DATA_COUNT; i++) begin
      view[i] = (data_wr && (data_idx == DATA_IDX_W'(i))) ? plain : store_r[i];
    end
  end

  assign dec_serial = {view[0], view[1], view[2], view[3]};

  always_comb begin
    result = '0;
    if (dec_serial == expected_serial) begin
      result.serial       = dec_serial;
      result.packet_count = {view[4], view[5]};
      result.avg_time     = {view[6], view[7]};
      result.pulse_count  = {view[8], view[9], view[10], view[11]};
      result.power_level  = view[12];
      result.serial_match = 1'b1;
    end
  end

endmodule

// File: rtl/sensor_packet_xor_descrambler_unit.sv
// Top level of the sensor packet XOR descrambler.
// Takes one received packet byte per cycle unless in_stall is high and, after
// the last byte of each PACKET_BYTES-byte packet, delivers one decoded result:
// serial, packet count, average time, pulse count and power, all zero with
// serial_match low when the decoded serial differs from the configured one. A
// byte with in_packet_start high is byte 0 of a packet; otherwise the position
// simply advances and wraps after the last byte. Bytes are accepted back to
// back at one per cycle while in_stall is low; a packet's last byte is captured
// in the input register, and the single descramble-and-unpack pass loads its
// result into the output register. The expected serial is written through
// the cfg_ port, which is always ready, and should only change between packets.
module sensor_packet_xor_descrambler_unit import spxd_pkg::*; #(
  parameter int PACKET_BYTES = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_packet_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_serial,
  output logic [15:0] out_packet_count,
  output logic [15:0] out_avg_time,
  output logic [31:0] out_pulse_count,
  output logic [7:0]  out_power_level,
  output logic        out_serial_match,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_expected_serial
);

  logic         cfg_wr;
  logic [31:0]  serial_r;
  logic         in_vld_r;
  byte_t        in_byte_r;
  logic         in_start_r;
  logic         out_vld_r;
  spxd_result_t out_r;
  logic         out_free;
  logic         step;
  logic         last;
  spxd_result_t result;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serial_r <= '0;
    end else if (cfg_wr) begin
      serial_r <= cfg_expected_serial;
    end
  end

  // A byte that completes a packet may only move on when the output register
  // is empty or being emptied in this cycle.
  assign out_free = !out_vld_r || !out_stall;
  assign step     = in_vld_r && (!last || out_free);
  assign in_stall = in_vld_r && !step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r  <= in_pkt_byte;
      in_start_r <= in_packet_start;
    end
  end

  spxd_frame #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .pkt_byte        (in_byte_r),
    .packet_start    (in_start_r),
    .expected_serial (serial_r),
    .last            (last),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_serial       = out_r.serial;
  assign out_packet_count = out_r.packet_count;
  assign out_avg_time     = out_r.avg_time;
  assign out_pulse_count  = out_r.pulse_count;
  assign out_power_level  = out_r.power_level;
  assign out_serial_match = out_r.serial_match;

endmodule
